### sv/lcs_pkg.sv
// Shared types, constants and helpers for the LRU cache set controller.
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int WAYS    = 8;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W   = 32;
    localparam int STAMP_W = 64;
    localparam int LINE_W  = TAG_W + STAMP_W;
    localparam int SUM_W   = 32;

    typedef logic [WAY_W-1:0]   way_t;
    typedef logic [TAG_W-1:0]   tag_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [WAYS-1:0]    way_vec_t;
    typedef logic [SUM_W-1:0]   sum_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic valid;
        way_t way;
    } cmp_t;

    typedef struct packed {
        logic found;
        way_t hit_way;
        way_t min_way;
        tag_t min_tag;
    } scan_res_t;

    function automatic way_t lowest_free(input way_vec_t used);
        way_t w;
        w = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!used[i]) begin
                w = way_t'(i);
            end
        end
        return w;
    endfunction

    // Checksum term of an occupied line: tag above valid and dirty, kept to 32 bits.
    function automatic sum_t line_term(input tag_t t, input logic dirty);
        return {t[SUM_W-3:0], 1'b1, dirty};
    endfunction

endpackage

### sv/lcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/lcs_scan.sv
// Way scan: tag match and minimum-stamp search over lines streamed from the RAM.
`timescale 1ns / 1ps

module lcs_scan (
    input  logic               aclk,
    input  lcs_pkg::cmp_t      cmp,
    input  lcs_pkg::way_vec_t  used,
    input  lcs_pkg::tag_t      req_tag,
    input  logic [lcs_pkg::LINE_W-1:0] line,
    output lcs_pkg::scan_res_t res
);
    import lcs_pkg::*;

    tag_t      line_tag;
    stamp_t    line_stamp;
    logic      match;
    logic      first;
    scan_res_t res_reg;
    scan_res_t res_next;

    assign line_tag   = line[LINE_W-1:STAMP_W];
    assign line_stamp = line[STAMP_W-1:0];
    assign match      = used[cmp.way] && (line_tag == req_tag);
    assign first      = (cmp.way == '0);

    stamp_t min_stamp_reg;
    stamp_t min_stamp_next;

    always_comb begin
        res_next       = res_reg;
        min_stamp_next = min_stamp_reg;
        if (cmp.valid) begin
            if (first) begin
                res_next.found   = match;
                res_next.hit_way = cmp.way;
            end else if (match && !res_reg.found) begin
                res_next.found   = 1'b1;
                res_next.hit_way = cmp.way;
            end
            if (first || (line_stamp < min_stamp_reg)) begin
                min_stamp_next   = line_stamp;
                res_next.min_way = cmp.way;
                res_next.min_tag = line_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg       <= res_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign res = res_reg;

endmodule

### sv/lru_cache_set_controller.sv
// LRU cache set controller: one set of WAYS lines, tag and stamp held in a RAM.
// Per request the RAM is read once per way, then a compare drain state and a
// write-back state follow; a new request is accepted only back in idle, after the
// write-back, since the single RAM read port scans the ways.
// A result not yet taken holds the write-back cycle until m_ready.
// Reset (synchronous, aresetn low) clears occupancy, dirty marks and checksum.
`timescale 1ns / 1ps

module lru_cache_set_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [31:0]           s_tag,
    input  logic [63:0]           s_cycle_stamp,
    input  logic [31:0]           s_checksum_seed,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic                  m_evicted,
    output logic [31:0]           m_victim_tag,
    output logic                  m_victim_dirty,
    output logic [31:0]           m_checksum_out
);
    import lcs_pkg::*;

    state_t    state_reg, state_next;
    way_t      cnt_reg, cnt_next;
    cmp_t      cmp_reg, cmp_next;
    way_vec_t  used_reg, used_next;
    way_vec_t  dirty_reg, dirty_next;
    sum_t      sum_reg, sum_next;
    logic      m_valid_reg, m_valid_next;

    logic      req_wr_reg;
    tag_t      req_tag_reg;
    stamp_t    req_stamp_reg;
    sum_t      req_seed_reg;

    logic      m_hit_reg, m_evicted_reg, m_victim_dirty_reg;
    tag_t      m_victim_tag_reg;
    sum_t      m_checksum_reg;

    logic [LINE_W-1:0] ram_rdata;
    logic      ram_re, ram_we;
    logic      accept, out_free, last_way, commit;
    scan_res_t scan;

    logic      full, evict, dirty_old, dirty_new;
    way_t      wr_way;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_way = (cnt_reg == way_t'(WAYS - 1));
    assign commit   = (state_reg == ST_WRITE) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_SCAN;
            ST_SCAN:  if (last_way) state_next = ST_LAST;
            ST_LAST:  state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        ram_re  = 1'b0;
        ram_we  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_SCAN:  ram_re  = 1'b1;
            ST_LAST:  ;
            ST_WRITE: ram_we  = out_free;
            default:  ;
        endcase
    end

    always_comb begin
        cnt_next       = cnt_reg;
        cmp_next.valid = ram_re;
        cmp_next.way   = cnt_reg;
        if (accept) begin
            cnt_next = '0;
        end else if (ram_re && !last_way) begin
            cnt_next = cnt_reg + way_t'(1);
        end
    end

    assign full      = &used_reg;
    assign evict     = !scan.found && full;
    assign wr_way    = scan.found ? scan.hit_way : (full ? scan.min_way : lowest_free(used_reg));
    assign dirty_old = dirty_reg[wr_way];
    assign dirty_new = scan.found ? (dirty_old | req_wr_reg) : req_wr_reg;

    always_comb begin
        used_next    = used_reg;
        dirty_next   = dirty_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (commit) begin
            used_next[wr_way]  = 1'b1;
            dirty_next[wr_way] = dirty_new;
            if (scan.found) begin
                sum_next = sum_reg ^ {{(SUM_W-1){1'b0}}, dirty_old ^ dirty_new};
            end else if (evict) begin
                sum_next = sum_reg ^ line_term(scan.min_tag, dirty_old)
                                   ^ line_term(req_tag_reg, req_wr_reg);
            end else begin
                sum_next = sum_reg ^ line_term(req_tag_reg, req_wr_reg);
            end
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            cmp_reg     <= '0;
            used_reg    <= '0;
            dirty_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_reg     <= cmp_next;
            used_reg    <= used_next;
            dirty_reg   <= dirty_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_wr_reg    <= s_req_type;
            req_tag_reg   <= s_tag;
            req_stamp_reg <= s_cycle_stamp;
            req_seed_reg  <= s_checksum_seed;
        end
        if (commit) begin
            m_hit_reg          <= scan.found;
            m_evicted_reg      <= evict;
            m_victim_tag_reg   <= evict ? scan.min_tag : '0;
            m_victim_dirty_reg <= evict && dirty_old;
            m_checksum_reg     <= req_seed_reg ^ sum_next;
        end
    end

    lcs_ram #(
        .WIDTH (LINE_W),
        .DEPTH (WAYS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_way),
        .wdata ({req_tag_reg, req_stamp_reg}),
        .re    (ram_re),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    lcs_scan u_scan (
        .aclk    (aclk),
        .cmp     (cmp_reg),
        .used    (used_reg),
        .req_tag (req_tag_reg),
        .line    (ram_rdata),
        .res     (scan)
    );

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_victim_tag   = m_victim_tag_reg;
    assign m_victim_dirty = m_victim_dirty_reg;
    assign m_checksum_out = m_checksum_reg;

`ifndef NO_ASSERTIONS
    a_result_from_write : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result raised outside write-back");

    a_used_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ((used_reg & $past(used_reg)) == $past(used_reg)))
        else $error("occupied line lost its mark");

    a_commit_done : assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("write-back did not deliver a result");

    a_evict_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !scan.found && !full) |=> !m_evicted_reg)
        else $error("eviction with a free line");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for the LRU cache set controller: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import lcs_pkg::*;

    localparam int CLK_HI       = 6;
    localparam int CLK_LO       = 6;
    localparam int RST_CYCLES   = 7;
    localparam int DIR_N        = 21;
    localparam int RAND_N       = 800;
    localparam int MAX_GAP      = 18;
    localparam int POOL_N       = 12;
    localparam int PAUSE_AT     = 400;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 40;
    localparam int WDOG_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 100;
    localparam stamp_t STAMP_MAX = '1;

    typedef struct packed {
        logic   req_type;
        tag_t   tag;
        stamp_t stamp;
        sum_t   seed;
    } access_t;

    typedef struct packed {
        logic hit;
        logic evicted;
        tag_t victim_tag;
        logic victim_dirty;
        sum_t checksum;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [31:0] s_tag;
    logic [63:0] s_cycle_stamp;
    logic [31:0] s_checksum_seed;
    logic        m_valid;
    logic        m_ready;
    logic        m_hit;
    logic        m_evicted;
    logic [31:0] m_victim_tag;
    logic        m_victim_dirty;
    logic [31:0] m_checksum_out;

    // mirror of the set
    bit [TAG_W-1:0]   way_tag   [WAYS];
    bit [STAMP_W-1:0] way_stamp [WAYS];
    bit               way_used  [WAYS];
    bit               way_valid [WAYS];
    bit               way_dirty [WAYS];

    outcome_t pending_outcomes[$];
    access_t  cur_acc;
    bit       cur_typed;
    outcome_t cur_want;
    int       mismatch_count = 0;
    int       results_seen   = 0;
    int       ready_wait     = 0;
    bit       rx_idle_on     = 1'b1;
    bit       tx_idle_on     = 1'b1;
    int       idle_cycles    = 0;

    lru_cache_set_controller dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_tag           (s_tag),
        .s_cycle_stamp   (s_cycle_stamp),
        .s_checksum_seed (s_checksum_seed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_evicted       (m_evicted),
        .m_victim_tag    (m_victim_tag),
        .m_victim_dirty  (m_victim_dirty),
        .m_checksum_out  (m_checksum_out)
    );

    always begin
        #CLK_HI aclk = 1'b1;
        #CLK_LO aclk = 1'b0;
    end

    function automatic access_t mk_access(input logic rt, input tag_t t, input stamp_t st,
                                          input sum_t seed);
        access_t a;
        a.req_type = rt;
        a.tag      = t;
        a.stamp    = st;
        a.seed     = seed;
        return a;
    endfunction

    function automatic outcome_t predict_access(input access_t a);
        outcome_t o;
        int       hw;
        int       v;
        o  = '0;
        hw = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (hw < 0 && way_used[w] && way_tag[w] == a.tag) begin
                hw = w;
            end
        end
        if (hw >= 0) begin
            o.hit = 1'b1;
            way_stamp[hw] = a.stamp;
            if (a.req_type) begin
                way_dirty[hw] = 1'b1;
            end
        end else begin
            v = -1;
            for (int w = 0; w < WAYS; w++) begin
                if (v < 0 && !way_used[w]) begin
                    v = w;
                end
            end
            if (v < 0) begin
                v = 0;
                for (int w = 1; w < WAYS; w++) begin
                    if (way_stamp[w] < way_stamp[v]) begin
                        v = w;
                    end
                end
                o.evicted      = 1'b1;
                o.victim_tag   = way_tag[v];
                o.victim_dirty = way_dirty[v];
            end
            way_used[v]  = 1'b1;
            way_valid[v] = 1'b1;
            way_dirty[v] = a.req_type;
            way_tag[v]   = a.tag;
            way_stamp[v] = a.stamp;
        end
        o.checksum = a.seed;
        for (int w = 0; w < WAYS; w++) begin
            if (way_used[w]) begin
                o.checksum ^= {way_tag[w][TAG_W-3:0], way_valid[w], way_dirty[w]};
            end
        end
        return o;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    // result check and request capture
    always @(posedge aclk) begin
        outcome_t o;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: result with nothing expected, expected none, actual %0h",
                                 $time, m_checksum_out);
                    end
                end else begin
                    o = pending_outcomes.pop_front();
                    report_field("hit", 64'(o.hit), 64'(m_hit));
                    report_field("evicted", 64'(o.evicted), 64'(m_evicted));
                    report_field("victim_tag", 64'(o.victim_tag), 64'(m_victim_tag));
                    report_field("victim_dirty", 64'(o.victim_dirty), 64'(m_victim_dirty));
                    report_field("checksum_out", 64'(o.checksum), 64'(m_checksum_out));
                end
                results_seen++;
                if (results_seen % 64 == 0) begin
                    rx_idle_on = !rx_idle_on;
                end
                ready_wait = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (s_valid && s_ready) begin
                o = predict_access(cur_acc);
                if (cur_typed) begin
                    o = cur_want;
                end
                pending_outcomes.insert(pending_outcomes.size(), o);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        ready_wait = $urandom_range(0, MAX_GAP);
        forever begin
            @(negedge aclk);
            if (aresetn && results_seen == HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (ready_wait > 0) begin
                m_ready <= 1'b0;
                ready_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic drive_request(input access_t a, input bit typed, input outcome_t want);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        cur_acc   = a;
        cur_typed = typed;
        cur_want  = want;
        s_req_type      <= a.req_type;
        s_tag           <= a.tag;
        s_cycle_stamp   <= a.stamp;
        s_checksum_seed <= a.seed;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // sender
    initial begin
        access_t  dir_acc   [DIR_N];
        bit       dir_typed [DIR_N];
        outcome_t dir_want  [DIR_N];
        tag_t     tag_pool  [POOL_N];
        stamp_t   stamp_ctr;
        stamp_t   st;
        tag_t     t;
        int       r;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_req_type      = 1'b0;
        s_tag           = '0;
        s_cycle_stamp   = '0;
        s_checksum_seed = '0;

        for (int i = 0; i < DIR_N; i++) begin
            dir_typed[i] = 1'b0;
            dir_want[i]  = '0;
        end
        dir_acc[0]  = mk_access(1'b0, 32'h0, 64'd0, 32'h0);
        dir_acc[1]  = mk_access(1'b1, 32'hFFFF_FFFF, STAMP_MAX, 32'hFFFF_FFFF);
        dir_acc[2]  = mk_access(1'b1, 32'h0, 64'd5, 32'h0);
        dir_acc[3]  = mk_access(1'b0, 32'd1, 64'd100, 32'h1357_9BDF);
        dir_acc[4]  = mk_access(1'b0, 32'd2, 64'd100, 32'h2468_ACE0);
        dir_acc[5]  = mk_access(1'b0, 32'd3, 64'd100, 32'h0);
        dir_acc[6]  = mk_access(1'b0, 32'd4, 64'd100, 32'hFFFF_FFFF);
        dir_acc[7]  = mk_access(1'b0, 32'd5, 64'd100, 32'h8000_0001);
        dir_acc[8]  = mk_access(1'b0, 32'd6, 64'd100, 32'h0);
        dir_acc[9]  = mk_access(1'b0, 32'd1, 64'd100, 32'h0);
        // full set: oldest line goes, then lowest of the equal stamps
        dir_acc[10] = mk_access(1'b0, 32'h1234_5678, 64'd300, 32'h0);
        dir_acc[11] = mk_access(1'b1, 32'hABCD_EF01, 64'd300, 32'h5555_5555);
        // stamp going backwards makes a line the victim
        dir_acc[12] = mk_access(1'b0, 32'hFFFF_FFFF, 64'd0, 32'h0);
        dir_acc[13] = mk_access(1'b1, 32'h8000_0000, 64'd400, 32'hAAAA_AAAA);
        dir_acc[14] = mk_access(1'b0, 32'h8000_0000, 64'd1, 32'h0);
        dir_acc[15] = mk_access(1'b1, 32'd7, 64'd500, 32'h0);
        dir_acc[16] = mk_access(1'b0, 32'd8, 64'h8000_0000_0000_0000, 32'h0F0F_0F0F);
        dir_acc[17] = mk_access(1'b0, 32'd9, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
        dir_acc[18] = mk_access(1'b1, 32'h5A5A_5A5A, STAMP_MAX, 32'hFFFF_FFFF);
        dir_acc[19] = mk_access(1'b0, 32'd7, 64'd0, 32'h0);
        dir_acc[20] = mk_access(1'b0, 32'd10, 64'd600, 32'h0);
        dir_typed[0] = 1'b1;
        dir_want[0]  = {1'b0, 1'b0, 32'h0, 1'b0, 32'h0000_0002};
        dir_typed[1] = 1'b1;
        dir_want[1]  = {1'b0, 1'b0, 32'h0, 1'b0, 32'h0000_0002};

        for (int i = 0; i < POOL_N; i++) begin
            tag_pool[i] = $urandom;
        end
        stamp_ctr = 64'd1000;

        repeat (RST_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            drive_request(dir_acc[i], dir_typed[i], dir_want[i]);
        end

        for (int i = 0; i < RAND_N; i++) begin
            if (i % 64 == 63) begin
                tx_idle_on = !tx_idle_on;
            end
            if (i == PAUSE_AT) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (pending_outcomes.size() != 0) @(posedge aclk);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                t = tag_pool[$urandom_range(0, POOL_N - 1)];
            end else if (r < 78) begin
                t = $urandom;
                tag_pool[$urandom_range(0, POOL_N - 1)] = t;
            end else begin
                t = $urandom;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                stamp_ctr = stamp_ctr + 64'($urandom_range(1, 20));
                st = stamp_ctr;
            end else if (r < 88) begin
                st = stamp_ctr;
            end else if (r < 94) begin
                st = {$urandom, $urandom};
            end else if (r < 97) begin
                st = '0;
            end else begin
                st = STAMP_MAX;
            end
            drive_request(mk_access(1'($urandom_range(0, 1)), t, st, $urandom), 1'b0, '0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
sv/lcs_pkg.sv
sv/lcs_ram.sv
sv/lcs_scan.sv
sv/lru_cache_set_controller.sv
bench/tb.sv
